// ===== hdl/lfma_pkg.sv =====
// lattice fourier mode accumulator: shared types, constants and the trig table
`timescale 1ns / 1ps

package lfma_pkg;

    localparam int POS_W     = 5;
    localparam int WAVE_W    = 4;
    localparam int CHARGE_W  = 4;
    localparam int PHASE_W   = 5;
    localparam int TRIG_W    = 16;
    localparam int DENSITY_W = 32;
    localparam int QSUM_W    = 36;
    localparam int PROD_W    = TRIG_W + CHARGE_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_Z = 2'd2;

    typedef logic signed [TRIG_W-1:0] t_trig;

    typedef struct packed {
        t_trig cos_val;
        t_trig sin_val;
    } t_trig_pair;

    // cos of k * pi/16 for k in 0..8, q1.14 rounded half away from zero
    function automatic t_trig quarter_wave(input logic [3:0] k);
        t_trig v;
        unique case (k)
            4'd0:    v = 16'sd16384;
            4'd1:    v = 16'sd16069;
            4'd2:    v = 16'sd15137;
            4'd3:    v = 16'sd13623;
            4'd4:    v = 16'sd11585;
            4'd5:    v = 16'sd9102;
            4'd6:    v = 16'sd6270;
            4'd7:    v = 16'sd3196;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // cos and sin of 2*pi*idx/32 built from the quarter wave by quadrant symmetry
    function automatic t_trig_pair trig_lookup(input logic [PHASE_W-1:0] idx);
        t_trig_pair  p;
        logic [3:0]  r;
        logic [3:0]  rc;
        t_trig       a;
        t_trig       b;
        r  = {1'b0, idx[2:0]};
        rc = 4'd8 - r;
        a  = quarter_wave(r);
        b  = quarter_wave(rc);
        unique case (idx[4:3])
            2'd0: begin
                p.cos_val = a;
                p.sin_val = b;
            end
            2'd1: begin
                p.cos_val = -b;
                p.sin_val = a;
            end
            2'd2: begin
                p.cos_val = -a;
                p.sin_val = -b;
            end
            default: begin
                p.cos_val = b;
                p.sin_val = -a;
            end
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/lattice_fourier_mode_accumulator.sv =====
// lattice fourier mode accumulator: top level with input stage, accumulators and result register
`timescale 1ns / 1ps

// Streams particles and sums the Fourier mode of the set at one wave vector.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index (0 wave_x, 1 wave_y,
// 2 wave_z, others ignored) and i_cfg_data; o_cfg_ready is always high. Write
// only while no particle is in flight.
// Input channel: one particle per beat (position, 4-bit signed charge, last
// flag), taken when i_in_valid is high and o_in_stall is low.
// Output channel: one beat per set, on the particle that carries the last
// flag, holding the four sums; taken when o_out_valid is high and i_out_stall
// is low. Particles without the last flag give no beat.
// Throughput is one particle per cycle. The phase index, table lookup, charge
// multiply and four adds sit between the input register and the accumulators.
// A last particle's sums go from the input register, through the accumulator
// adds, into the result register that drives the output. A stalled result
// holds; non-last particles keep flowing, and o_in_stall rises only when a
// last particle waits on a full result register.
// Reset clears wave registers, accumulators and both valid flags.

module lattice_fourier_mode_accumulator (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [lfma_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [lfma_pkg::WAVE_W-1:0]             i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [lfma_pkg::POS_W-1:0]              i_pos_x,
    input  logic [lfma_pkg::POS_W-1:0]              i_pos_y,
    input  logic [lfma_pkg::POS_W-1:0]              i_pos_z,
    input  logic signed [lfma_pkg::CHARGE_W-1:0]    i_charge,
    input  logic                                    i_last_particle,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [lfma_pkg::DENSITY_W-1:0]   o_density_re,
    output logic signed [lfma_pkg::DENSITY_W-1:0]   o_density_im,
    output logic signed [lfma_pkg::QSUM_W-1:0]      o_charge_re,
    output logic signed [lfma_pkg::QSUM_W-1:0]      o_charge_im
);

    logic [lfma_pkg::WAVE_W-1:0]            r_wave_x;
    logic [lfma_pkg::WAVE_W-1:0]            r_wave_y;
    logic [lfma_pkg::WAVE_W-1:0]            r_wave_z;

    logic                                   r_vld;
    logic [lfma_pkg::POS_W-1:0]             r_pos_x;
    logic [lfma_pkg::POS_W-1:0]             r_pos_y;
    logic [lfma_pkg::POS_W-1:0]             r_pos_z;
    logic signed [lfma_pkg::CHARGE_W-1:0]   r_charge;
    logic                                   r_last;

    logic signed [lfma_pkg::DENSITY_W-1:0]  r_acc_dre;
    logic signed [lfma_pkg::DENSITY_W-1:0]  r_acc_dim;
    logic signed [lfma_pkg::QSUM_W-1:0]     r_acc_qre;
    logic signed [lfma_pkg::QSUM_W-1:0]     r_acc_qim;

    logic                                   r_out_vld;
    logic signed [lfma_pkg::DENSITY_W-1:0]  r_out_dre;
    logic signed [lfma_pkg::DENSITY_W-1:0]  r_out_dim;
    logic signed [lfma_pkg::QSUM_W-1:0]     r_out_qre;
    logic signed [lfma_pkg::QSUM_W-1:0]     r_out_qim;

    logic                                   in_accept;
    logic                                   out_accept;
    logic                                   adv;
    logic                                   load_out;

    logic [2*lfma_pkg::POS_W-1:0]           prod_x;
    logic [2*lfma_pkg::POS_W-1:0]           prod_y;
    logic [2*lfma_pkg::POS_W-1:0]           prod_z;
    logic [2*lfma_pkg::POS_W+1:0]           phase_sum;
    logic [lfma_pkg::PHASE_W-1:0]           phase_idx;
    lfma_pkg::t_trig_pair                   trig;
    logic signed [lfma_pkg::PROD_W-1:0]     qcos;
    logic signed [lfma_pkg::PROD_W-1:0]     qsin;

    logic signed [lfma_pkg::DENSITY_W-1:0]  n_sum_dre;
    logic signed [lfma_pkg::DENSITY_W-1:0]  n_sum_dim;
    logic signed [lfma_pkg::QSUM_W-1:0]     n_sum_qre;
    logic signed [lfma_pkg::QSUM_W-1:0]     n_sum_qim;

    // handshake
    assign o_cfg_ready = 1'b1;
    assign out_accept  = r_out_vld && !i_out_stall;
    assign adv         = r_vld && (!r_last || !r_out_vld || !i_out_stall);
    assign load_out    = adv && r_last;
    assign o_in_stall  = r_vld && !adv;
    assign in_accept   = i_in_valid && !o_in_stall;

    // phase index mod 32
    always_comb begin
        prod_x    = {{lfma_pkg::POS_W-lfma_pkg::WAVE_W{1'b0}}, r_wave_x} * r_pos_x;
        prod_y    = {{lfma_pkg::POS_W-lfma_pkg::WAVE_W{1'b0}}, r_wave_y} * r_pos_y;
        prod_z    = {{lfma_pkg::POS_W-lfma_pkg::WAVE_W{1'b0}}, r_wave_z} * r_pos_z;
        phase_sum = {2'b00, prod_x} + {2'b00, prod_y} + {2'b00, prod_z};
        phase_idx = phase_sum[lfma_pkg::PHASE_W-1:0];
        trig      = lfma_pkg::trig_lookup(phase_idx);
        qcos      = r_charge * trig.cos_val;
        qsin      = r_charge * trig.sin_val;
        n_sum_dre = r_acc_dre + lfma_pkg::DENSITY_W'(trig.cos_val);
        n_sum_dim = r_acc_dim + lfma_pkg::DENSITY_W'(trig.sin_val);
        n_sum_qre = r_acc_qre + lfma_pkg::QSUM_W'(qcos);
        n_sum_qim = r_acc_qim + lfma_pkg::QSUM_W'(qsin);
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_x <= '0;
            r_wave_y <= '0;
            r_wave_z <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lfma_pkg::CFG_WAVE_X: r_wave_x <= i_cfg_data;
                lfma_pkg::CFG_WAVE_Y: r_wave_y <= i_cfg_data;
                lfma_pkg::CFG_WAVE_Z: r_wave_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc_dre <= '0;
            r_acc_dim <= '0;
            r_acc_qre <= '0;
            r_acc_qim <= '0;
        end else begin
            if (in_accept) begin
                r_vld <= 1'b1;
            end else if (adv) begin
                r_vld <= 1'b0;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (out_accept) begin
                r_out_vld <= 1'b0;
            end
            if (load_out) begin
                r_acc_dre <= '0;
                r_acc_dim <= '0;
                r_acc_qre <= '0;
                r_acc_qim <= '0;
            end else if (adv) begin
                r_acc_dre <= n_sum_dre;
                r_acc_dim <= n_sum_dim;
                r_acc_qre <= n_sum_qre;
                r_acc_qim <= n_sum_qim;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pos_x  <= i_pos_x;
            r_pos_y  <= i_pos_y;
            r_pos_z  <= i_pos_z;
            r_charge <= i_charge;
            r_last   <= i_last_particle;
        end
        if (load_out) begin
            r_out_dre <= n_sum_dre;
            r_out_dim <= n_sum_dim;
            r_out_qre <= n_sum_qre;
            r_out_qim <= n_sum_qim;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_density_re = r_out_dre;
    assign o_density_im = r_out_dim;
    assign o_charge_re  = r_out_qre;
    assign o_charge_im  = r_out_qim;

    // checks
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_acc_dre == '0 && r_acc_dim == '0 && r_acc_qre == '0 && r_acc_qim == '0))
        else $error("accumulators not cleared after last particle");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_vld && r_last && r_out_vld && i_out_stall))
        else $error("input stalled without a blocked last particle");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_out_valid)
        else $error("result beat missing after last particle");

    a_acc_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld |=> ($stable(r_acc_dre) && $stable(r_acc_qre)))
        else $error("accumulators changed with no particle");

endmodule

// ===== dv/lfma_sum_checker.sv =====
// checker for the lattice fourier mode accumulator: predicts the mode sums of each set and compares them
`timescale 1ns / 1ps

module lfma_sum_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    input  logic                                    i_cfg_ready,
    input  logic [lfma_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [lfma_pkg::WAVE_W-1:0]             i_cfg_data,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_stall,
    input  logic [lfma_pkg::POS_W-1:0]              i_pos_x,
    input  logic [lfma_pkg::POS_W-1:0]              i_pos_y,
    input  logic [lfma_pkg::POS_W-1:0]              i_pos_z,
    input  logic signed [lfma_pkg::CHARGE_W-1:0]    i_charge,
    input  logic                                    i_last_particle,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_stall,
    input  logic signed [lfma_pkg::DENSITY_W-1:0]   i_density_re,
    input  logic signed [lfma_pkg::DENSITY_W-1:0]   i_density_im,
    input  logic signed [lfma_pkg::QSUM_W-1:0]      i_charge_re,
    input  logic signed [lfma_pkg::QSUM_W-1:0]      i_charge_im,
    output int                                      o_pending,
    output int                                      o_mismatches
);

    localparam int LATTICE = 32;
    localparam int TRIG_FRAC = 14;
    localparam int WORK_FRAC = 30;
    localparam int SERIES_LEN = 22;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [lfma_pkg::DENSITY_W-1:0] density_re;
        logic signed [lfma_pkg::DENSITY_W-1:0] density_im;
        logic signed [lfma_pkg::QSUM_W-1:0]    charge_re;
        logic signed [lfma_pkg::QSUM_W-1:0]    charge_im;
    } t_mode_sums;

    int cos_table [LATTICE];
    int sin_table [LATTICE];

    int wave_x;
    int wave_y;
    int wave_z;
    logic signed [lfma_pkg::DENSITY_W-1:0] sum_density_re;
    logic signed [lfma_pkg::DENSITY_W-1:0] sum_density_im;
    logic signed [lfma_pkg::QSUM_W-1:0]    sum_charge_re;
    logic signed [lfma_pkg::QSUM_W-1:0]    sum_charge_im;
    logic signed [lfma_pkg::QSUM_W-1:0]    weighted;
    t_mode_sums                            expected_sums [$];
    t_mode_sums                            want;
    t_mode_sums                            got;
    int                                    phase;
    int                                    charge;
    int                                    mismatches = 0;

    function automatic int round_to_trig(input longint v);
        longint unsigned mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << (WORK_FRAC - TRIG_FRAC - 1))) >> (WORK_FRAC - TRIG_FRAC);
        return (v < 0) ? -int'(mag) : int'(mag);
    endfunction

    function automatic int check_field(input string name, input logic signed [63:0] exp_val,
                                       input logic signed [63:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    // quarter-angle taylor series in q30, then quadrant symmetry
    initial begin
        longint unsigned turn;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned angle;
        longint unsigned term;
        longint          c_acc;
        longint          s_acc;
        longint          c_out;
        longint          s_out;
        int              n;
        int              k;
        for (n = 0; n < LATTICE; n++) begin
            turn  = 4 * n;
            quad  = turn / LATTICE;
            rem   = turn % LATTICE;
            angle = (HALF_PI_Q30 * rem + LATTICE / 2) / LATTICE;
            term  = 64'd1 << WORK_FRAC;
            c_acc = term;
            s_acc = 0;
            for (k = 1; k < SERIES_LEN; k++) begin
                term = ((term * angle) >> WORK_FRAC) / k;
                case (k % 4)
                    1: s_acc += term;
                    2: c_acc -= term;
                    3: s_acc -= term;
                    default: c_acc += term;
                endcase
            end
            case (quad % 4)
                0: begin
                    c_out = c_acc;
                    s_out = s_acc;
                end
                1: begin
                    c_out = -s_acc;
                    s_out = c_acc;
                end
                2: begin
                    c_out = -c_acc;
                    s_out = -s_acc;
                end
                default: begin
                    c_out = s_acc;
                    s_out = -c_acc;
                end
            endcase
            cos_table[n] = round_to_trig(c_out);
            sin_table[n] = round_to_trig(s_out);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wave_x         = 0;
            wave_y         = 0;
            wave_z         = 0;
            sum_density_re = '0;
            sum_density_im = '0;
            sum_charge_re  = '0;
            sum_charge_im  = '0;
            expected_sums.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lfma_pkg::CFG_WAVE_X: wave_x = int'(i_cfg_data);
                    lfma_pkg::CFG_WAVE_Y: wave_y = int'(i_cfg_data);
                    lfma_pkg::CFG_WAVE_Z: wave_z = int'(i_cfg_data);
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                got = '{i_density_re, i_density_im, i_charge_re, i_charge_im};
                if (expected_sums.size() == 0) begin
                    $error("result beat with no set pending: density_re %0d", i_density_re);
                    mismatches++;
                end else begin
                    want = expected_sums.pop_front();
                    mismatches += check_field("density_re", want.density_re, got.density_re);
                    mismatches += check_field("density_im", want.density_im, got.density_im);
                    mismatches += check_field("charge_re", want.charge_re, got.charge_re);
                    mismatches += check_field("charge_im", want.charge_im, got.charge_im);
                end
            end

            if (i_in_valid && !i_in_stall) begin
                phase = (wave_x * int'(i_pos_x) + wave_y * int'(i_pos_y)
                         + wave_z * int'(i_pos_z)) % LATTICE;
                charge = int'(i_charge);
                sum_density_re = sum_density_re + cos_table[phase];
                sum_density_im = sum_density_im + sin_table[phase];
                weighted       = charge * cos_table[phase];
                sum_charge_re  = sum_charge_re + weighted;
                weighted       = charge * sin_table[phase];
                sum_charge_im  = sum_charge_im + weighted;
                if (i_last_particle) begin
                    expected_sums.push_back('{sum_density_re, sum_density_im,
                                              sum_charge_re, sum_charge_im});
                    sum_density_re = '0;
                    sum_density_im = '0;
                    sum_charge_re  = '0;
                    sum_charge_im  = '0;
                end
            end
        end
        o_pending    <= expected_sums.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== dv/lattice_fourier_mode_accumulator_tb.sv =====
// testbench top for the lattice fourier mode accumulator: particle sets, wave vector loads, verdict
`timescale 1ns / 1ps

module lattice_fourier_mode_accumulator_tb;

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int RANDOM_PHASES = 6;
    localparam logic [lfma_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_cfg_valid;
    logic                                  o_cfg_ready;
    logic [lfma_pkg::CFG_IDX_W-1:0]        i_cfg_index;
    logic [lfma_pkg::WAVE_W-1:0]           i_cfg_data;
    logic                                  i_in_valid;
    logic                                  o_in_stall;
    logic [lfma_pkg::POS_W-1:0]            i_pos_x;
    logic [lfma_pkg::POS_W-1:0]            i_pos_y;
    logic [lfma_pkg::POS_W-1:0]            i_pos_z;
    logic signed [lfma_pkg::CHARGE_W-1:0]  i_charge;
    logic                                  i_last_particle;
    logic                                  o_out_valid;
    logic                                  i_out_stall;
    logic signed [lfma_pkg::DENSITY_W-1:0] o_density_re;
    logic signed [lfma_pkg::DENSITY_W-1:0] o_density_im;
    logic signed [lfma_pkg::QSUM_W-1:0]    o_charge_re;
    logic signed [lfma_pkg::QSUM_W-1:0]    o_charge_im;

    int pending_sets;
    int mismatch_count;
    int idle_cycles = 0;
    bit no_gaps;

    lattice_fourier_mode_accumulator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_charge        (i_charge),
        .i_last_particle (i_last_particle),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_density_re    (o_density_re),
        .o_density_im    (o_density_im),
        .o_charge_re     (o_charge_re),
        .o_charge_im     (o_charge_im)
    );

    lfma_sum_checker u_sum_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_charge        (i_charge),
        .i_last_particle (i_last_particle),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_density_re    (o_density_re),
        .i_density_im    (o_density_im),
        .i_charge_re     (o_charge_re),
        .i_charge_im     (o_charge_im),
        .o_pending       (pending_sets),
        .o_mismatches    (mismatch_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_set_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 6);
        if (roll < 95) return $urandom_range(7, 30);
        return $urandom_range(31, 120);
    endfunction

    function automatic logic signed [lfma_pkg::CHARGE_W-1:0] pick_charge();
        if ($urandom_range(0, 4) == 0) return lfma_pkg::CHARGE_W'($urandom_range(0, 15));
        return lfma_pkg::CHARGE_W'(int'($urandom_range(0, 8)) - 4);
    endfunction

    function automatic logic [lfma_pkg::POS_W-1:0] pick_pos();
        return lfma_pkg::POS_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [lfma_pkg::WAVE_W-1:0] pick_wave();
        return lfma_pkg::WAVE_W'($urandom_range(0, 15));
    endfunction

    // one particle beat, held until taken
    task automatic send_particle(input logic [lfma_pkg::POS_W-1:0] x,
                                 input logic [lfma_pkg::POS_W-1:0] y,
                                 input logic [lfma_pkg::POS_W-1:0] z,
                                 input logic signed [lfma_pkg::CHARGE_W-1:0] q,
                                 input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_pos_x         <= x;
        i_pos_y         <= y;
        i_pos_z         <= z;
        i_charge        <= q;
        i_last_particle <= last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random_set(input int len, input bit closed);
        int i;
        no_gaps = ($urandom_range(0, 3) == 0);
        for (i = 0; i < len; i++) begin
            send_particle(pick_pos(), pick_pos(), pick_pos(),
                          pick_charge(), closed && (i == len - 1));
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_sets != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_wave(input logic [lfma_pkg::WAVE_W-1:0] wx,
                             input logic [lfma_pkg::WAVE_W-1:0] wy,
                             input logic [lfma_pkg::WAVE_W-1:0] wz, input bit with_spare);
        logic [lfma_pkg::CFG_IDX_W-1:0] idx [4];
        logic [lfma_pkg::WAVE_W-1:0]    val [4];
        int                             count;
        int                             i;
        count = 0;
        if (with_spare) begin
            idx[count] = CFG_SPARE;
            val[count] = pick_wave();
            count++;
        end
        idx[count] = lfma_pkg::CFG_WAVE_X;
        val[count] = wx;
        count++;
        idx[count] = lfma_pkg::CFG_WAVE_Y;
        val[count] = wy;
        count++;
        idx[count] = lfma_pkg::CFG_WAVE_Z;
        val[count] = wz;
        count++;
        i_cfg_valid <= 1'b1;
        for (i = 0; i < count; i++) begin
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // result side back-pressure: free runs, random stalls and long holds
    initial begin
        int mode;
        int run;
        i_out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 9);
            run  = $urandom_range(5, 40);
            if (mode == 9) run = $urandom_range(20, 60);
            repeat (run) begin
                @(posedge i_clk);
                case (mode)
                    0, 1, 2: i_out_stall <= 1'b0;
                    8:       i_out_stall <= 1'($urandom_range(0, 1));
                    9:       i_out_stall <= 1'b1;
                    default: i_out_stall <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("lattice_fourier_mode_accumulator_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int phase;
        int sent;
        int len;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_pos_x         = '0;
        i_pos_y         = '0;
        i_pos_z         = '0;
        i_charge        = '0;
        i_last_particle = 1'b0;
        no_gaps         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wave vector still at reset, every particle lands on phase zero
        send_particle(0, 0, 0, -8, 0);
        send_particle(31, 31, 31, 7, 0);
        send_particle(31, 0, 17, -4, 0);
        send_particle(5, 9, 2, 4, 1);
        send_particle(0, 0, 0, 0, 1);
        settle();

        load_wave(15, 15, 15, 1);
        send_particle(31, 31, 31, -8, 1);
        send_particle(0, 0, 0, 7, 1);
        send_particle(1, 2, 3, -1, 0);
        send_particle(31, 0, 0, 4, 0);
        send_particle(0, 31, 0, -4, 0);
        send_particle(0, 0, 31, 1, 1);
        send_particle(16, 8, 4, -3, 0);
        send_particle(30, 29, 27, 3, 1);
        settle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: load_wave(1, 0, 0, 1);
                1: load_wave(0, 15, 0, 0);
                2: load_wave(0, 0, 15, 1);
                3: load_wave(7, 11, 13, 0);
                default: load_wave(pick_wave(), pick_wave(), pick_wave(),
                                   1'($urandom_range(0, 1)));
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = pick_set_len();
                send_random_set(len, 1'b1);
                sent += len;
            end
            // an open set carries its partial sums into the next wave vector
            if ($urandom_range(0, 3) == 0) send_random_set($urandom_range(1, 5), 1'b0);
            settle();
        end

        if (mismatch_count == 0 && pending_sets == 0) begin
            $display("lattice_fourier_mode_accumulator_tb OK");
        end else begin
            $display("lattice_fourier_mode_accumulator_tb NOT OK");
        end
        $finish;
    end

endmodule
